>>> src/pl_pkg.sv
// Shared types and codes for the positional list engine.
// No dependencies.
package pl_pkg;

    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int QDEPTH   = 2;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_ERASE  = 2'd1;
    localparam logic [1:0] REQ_DUMP   = 2'd2;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_ERASE  = 2'd1;
    localparam logic [1:0] KIND_DUMP   = 2'd2;
    localparam logic [1:0] KIND_BAD    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cmd_t;

endpackage

>>> src/pl_front.sv
// Front end: accepts request items and classifies them into commands.
// Depends on pl_pkg.
module pl_front
    import pl_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[7:0], value[39:8]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        push,
    output cmd_t        push_cmd,
    input  logic        q_full
);

    logic neg;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;
    assign neg      = s_tdata[7];

    always_comb
    begin
        push_cmd.pos   = s_tdata[POS_W-1:0];
        push_cmd.value = s_tdata[8 +: DATA_W];
        case (s_tuser)
            REQ_INSERT: push_cmd.kind = neg ? KIND_BAD : KIND_INSERT;
            REQ_ERASE:  push_cmd.kind = neg ? KIND_BAD : KIND_ERASE;
            REQ_DUMP:   push_cmd.kind = KIND_DUMP;
            default:    push_cmd.kind = KIND_BAD;
        endcase
    end

endmodule

>>> src/pl_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on pl_pkg.
module pl_queue
    import pl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_cmd
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    cmd_t          mem_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full    = cnt_reg == CW'(QDEPTH);
    assign q_valid = cnt_reg != '0;
    assign q_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> src/pl_back.sv
// Back end: holds the sequence in shifting cells, executes commands and
// drives the registered result stage. Depends on pl_pkg.
module pl_back
    import pl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  cmd_t                q_cmd,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // entry_value[31:0], count[36:32], zero[39:37]
    output logic [STATUS_W-1:0] m_tuser,   // status[1:0]
    output logic                m_tlast
);

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [DATA_W-1:0]   entries_reg [CAPACITY];
    logic [FW-1:0]       fill_reg, fill_next;
    logic                dumping_reg, dumping_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                last_reg, last_next;

    logic              out_free;
    logic [POS_W-1:0]  fill7;
    logic              is_full;
    logic              ins_ok;
    logic              era_ok;
    logic              do_ins;
    logic              do_era;
    logic [FW-1:0]     idx_ext;
    logic              dump_last;

    assign out_free  = !out_valid_reg || m_tready;
    assign fill7     = POS_W'(fill_reg);
    assign is_full   = fill_reg == FW'(CAPACITY);
    assign ins_ok    = q_cmd.kind == KIND_INSERT && q_cmd.pos <= fill7 && !is_full;
    assign era_ok    = q_cmd.kind == KIND_ERASE && q_cmd.pos < fill7;
    assign do_ins    = pop && ins_ok;
    assign do_era    = pop && era_ok;
    assign idx_ext   = FW'(idx_reg);
    assign dump_last = (idx_ext + FW'(1)) == fill_reg;

    always_comb
    begin
        pop            = 1'b0;
        fill_next      = fill_reg;
        dumping_next   = dumping_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        if (out_free)
        begin
            if (dumping_reg)
            begin
                out_valid_next = 1'b1;
                status_next    = ST_OK;
                value_next     = entries_reg[idx_reg];
                count_next     = COUNT_W'(fill_reg);
                last_next      = dump_last;
                idx_next       = idx_reg + IW'(1);
                if (dump_last)
                begin
                    dumping_next = 1'b0;
                end
            end
            else
            begin
                out_valid_next = q_valid;
                pop            = q_valid;
                value_next     = '0;
                last_next      = 1'b1;
                count_next     = COUNT_W'(fill_reg);
                status_next    = ST_OK;
                case (q_cmd.kind)
                    KIND_INSERT:
                    begin
                        if (q_cmd.pos > fill7)
                        begin
                            status_next = ST_RANGE;
                        end
                        else if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (do_ins)
                        begin
                            fill_next  = fill_reg + FW'(1);
                            count_next = COUNT_W'(fill_reg + FW'(1));
                        end
                    end
                    KIND_ERASE:
                    begin
                        if (do_era)
                        begin
                            fill_next  = fill_reg - FW'(1);
                            count_next = COUNT_W'(fill_reg - FW'(1));
                        end
                        else
                        begin
                            status_next = ST_RANGE;
                        end
                    end
                    KIND_DUMP:
                    begin
                        if (fill_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            value_next = entries_reg[0];
                            last_next  = fill_reg == FW'(1);
                            idx_next   = IW'(1);
                            if (fill_reg != FW'(1))
                            begin
                                dumping_next = q_valid;
                            end
                        end
                    end
                    default:
                    begin
                        status_next = ST_RANGE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            dumping_reg   <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            dumping_reg   <= dumping_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
    end

    // one cell per entry; neighbors feed the insert and erase shifts
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] prev_val;
        logic [DATA_W-1:0] next_val;

        if (i > 0)
        begin : g_prev
            assign prev_val = entries_reg[i-1];
        end
        else
        begin : g_noprev
            assign prev_val = '0;
        end

        if (i < CAPACITY - 1)
        begin : g_next
            assign next_val = entries_reg[i+1];
        end
        else
        begin : g_nonext
            assign next_val = '0;
        end

        always_ff @(posedge clk)
        begin
            if (do_ins)
            begin
                if (POS_W'(i) == q_cmd.pos)
                begin
                    entries_reg[i] <= q_cmd.value;
                end
                else if (POS_W'(i) > q_cmd.pos && POS_W'(i) <= fill7)
                begin
                    entries_reg[i] <= prev_val;
                end
            end
            else if (do_era)
            begin
                if (POS_W'(i) >= q_cmd.pos && POS_W'(i + 1) < fill7)
                begin
                    entries_reg[i] <= next_val;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, count_reg, value_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(CAPACITY))
        else $error("fill count above capacity");

    a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
        dumping_reg |-> (idx_ext < fill_reg && idx_reg != '0))
        else $error("dump index outside the sequence");

    a_no_pop_dump: assert property (@(posedge clk) disable iff (!rst_n)
        dumping_reg |-> !pop)
        else $error("queue popped during a dump");

    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        do_ins |=> fill_reg == $past(fill_reg) + FW'(1))
        else $error("insert did not grow the sequence");

    a_era_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        do_era |=> fill_reg == $past(fill_reg) - FW'(1))
        else $error("erase did not shrink the sequence");

endmodule

>>> src/positional_list_engine.sv
// Positional list engine: an ordered sequence of signed words with
// insert, erase and dump requests. Depends on pl_pkg, pl_front, pl_queue,
// pl_back.
// Usage:
//   Requests arrive on the s_ channel: s_tuser is the request type
//   (insert, erase, dump), s_tdata carries the position and the value.
//   Results leave on the m_ channel: m_tuser is the status, m_tdata the
//   dumped entry and the entry count, m_tlast marks the final result of
//   a request. Insert, erase and rejected requests give one result; a
//   dump gives one result per entry, or a single empty status.
//   A request is accepted into a two-entry command queue; with nothing
//   queued, its result passes the queue, then the result register, to m_.
//   Insert and erase shift all affected cells at once, so the back end
//   completes one of them per cycle while the result register is free; a
//   dump holds the back end, one entry read from the cells per cycle.
//   Reset empties the sequence and the queue; cell contents are undefined
//   until written and are never read before that.
//   While a result waits with m_tready low, the result register and back end
//   hold; the front keeps accepting until the queue fills, then drops s_tready.
module positional_list_engine
    import pl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,   // position[7:0], value[39:8]
    input  logic [1:0]          s_tuser,   // req_type[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // entry_value[31:0], count[36:32], zero[39:37]
    output logic [STATUS_W-1:0] m_tuser,   // status[1:0]
    output logic                m_tlast
);

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic pop;
    logic q_valid;
    cmd_t q_cmd;

    pl_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    pl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    pl_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> dv/pl_result_checker.sv
// Result checker for the positional list engine: tracks the list contents
// from accepted requests and compares every accepted result in order.
// Depends on pl_pkg.
`timescale 1ns / 100ps

module pl_result_checker
    import pl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [39:0]         s_tdata,   // position[7:0], value[39:8]
    input  logic [1:0]          s_tuser,   // req_type[1:0]
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [39:0]         m_tdata,   // entry_value[31:0], count[36:32], zero[39:37]
    input  logic [STATUS_W-1:0] m_tuser,   // status[1:0]
    input  logic                m_tlast,
    output int                  errors,
    output int                  pending,
    output int                  requests_seen,
    output int                  results_seen,
    output int                  peak_len,
    output logic [COUNT_W-1:0]  list_len
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   entry_value;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } list_result_t;

    list_result_t      expected_results[$];
    list_result_t      want;
    list_result_t      got;
    logic [DATA_W-1:0] shadow_cells [CAPACITY];
    int                shadow_len;

    function automatic list_result_t make_result(input logic [STATUS_W-1:0] status,
                                                 input logic [DATA_W-1:0] value,
                                                 input int count,
                                                 input logic last);
        list_result_t r;
        r.status      = status;
        r.entry_value = value;
        r.count       = count[COUNT_W-1:0];
        r.last        = last;
        return r;
    endfunction

    task automatic apply_request(input logic [1:0] req, input logic [7:0] pos_raw,
                                 input logic [DATA_W-1:0] val);
        int   pos;
        logic neg;
        pos = pos_raw[6:0];
        neg = pos_raw[7];
        case (req)
            REQ_INSERT:
            begin
                if (neg || pos > shadow_len)
                    expected_results.push_back(make_result(ST_RANGE, '0, shadow_len, 1'b1));
                else if (shadow_len >= CAPACITY)
                    expected_results.push_back(make_result(ST_FULL, '0, shadow_len, 1'b1));
                else
                begin
                    for (int i = shadow_len; i > pos; i--)
                        shadow_cells[i] = shadow_cells[i - 1];
                    shadow_cells[pos] = val;
                    shadow_len++;
                    expected_results.push_back(make_result(ST_OK, '0, shadow_len, 1'b1));
                end
            end
            REQ_ERASE:
            begin
                if (neg || pos >= shadow_len)
                    expected_results.push_back(make_result(ST_RANGE, '0, shadow_len, 1'b1));
                else
                begin
                    for (int i = pos; i + 1 < shadow_len; i++)
                        shadow_cells[i] = shadow_cells[i + 1];
                    shadow_len--;
                    expected_results.push_back(make_result(ST_OK, '0, shadow_len, 1'b1));
                end
            end
            REQ_DUMP:
            begin
                if (shadow_len == 0)
                    expected_results.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
                else
                    for (int i = 0; i < shadow_len; i++)
                        expected_results.push_back(make_result(ST_OK, shadow_cells[i],
                                                               shadow_len,
                                                               i + 1 == shadow_len));
            end
            default:
                expected_results.push_back(make_result(ST_RANGE, '0, shadow_len, 1'b1));
        endcase
    endtask

    task automatic report(input string field, input logic [DATA_W-1:0] exp_v,
                          input logic [DATA_W-1:0] act_v);
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, exp_v, act_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            shadow_len    = 0;
            errors        = 0;
            pending       = 0;
            requests_seen = 0;
            results_seen  = 0;
            peak_len      = 0;
            list_len      = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                requests_seen++;
                apply_request(s_tuser, s_tdata[7:0], s_tdata[39:8]);
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got = make_result(m_tuser, m_tdata[31:0], int'(m_tdata[36:32]), m_tlast);
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item, expected none, got %0h", $realtime, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report("status", DATA_W'(want.status), DATA_W'(got.status));
                    if (got.entry_value !== want.entry_value)
                        report("entry_value", want.entry_value, got.entry_value);
                    if (got.count !== want.count)
                        report("count", DATA_W'(want.count), DATA_W'(got.count));
                    if (got.last !== want.last)
                        report("last", DATA_W'(want.last), DATA_W'(got.last));
                    if (m_tdata[39:37] !== 3'b000)
                        report("tdata pad", '0, DATA_W'(m_tdata[39:37]));
                end
            end
            pending  = expected_results.size();
            list_len = shadow_len[COUNT_W-1:0];
            if (shadow_len > peak_len)
                peak_len = shadow_len;
        end
    end

endmodule

>>> dv/testbench.sv
// Top of the positional list engine regression: clock, reset, request
// stimulus, output backpressure and verdict. Depends on pl_pkg,
// positional_list_engine and pl_result_checker.
`timescale 1ns / 100ps

module testbench;
    import pl_pkg::*;

    localparam int         LIST_CAPACITY = 16;
    localparam int         RANDOM_ITEMS  = 180;
    localparam int         QUIET_LIMIT   = 5000;
    localparam logic [1:0] REQ_UNKNOWN   = 2'd3;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [39:0]         s_tdata  = '0;
    logic [1:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [39:0]         m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                m_tlast;

    logic                calm     = 1'b0;
    int                  quiet_cycles = 0;
    int                  directed_count = 0;

    int                  errors;
    int                  pending;
    int                  requests_seen;
    int                  results_seen;
    int                  peak_len;
    logic [COUNT_W-1:0]  list_len;

    positional_list_engine #(.CAPACITY(LIST_CAPACITY)) i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    pl_result_checker #(.CAPACITY(LIST_CAPACITY)) i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .errors        (errors),
        .pending       (pending),
        .requests_seen (requests_seen),
        .results_seen  (results_seen),
        .peak_len      (peak_len),
        .list_len      (list_len)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready <= rst_n && (calm || $urandom_range(99) >= 25);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout at %0t with %0d items outstanding", $realtime, pending);
            $display("positional_list_engine regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic [1:0] req, input logic [7:0] pos,
                                input logic [31:0] val);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 25)
            gap = $urandom_range(1, 4);
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {val, pos};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic send_mixed();
        int pick;
        int len;
        pick = $urandom_range(99);
        len  = list_len;
        if (pick < 40)
            send_request(REQ_INSERT, 8'($urandom_range(0, len)), rand_word());
        else if (pick < 65 && len > 0)
            send_request(REQ_ERASE, 8'($urandom_range(0, len - 1)), rand_word());
        else if (pick < 75)
            send_request(REQ_DUMP, 8'($urandom_range(255)), rand_word());
        else
            send_request(2'($urandom_range(3)), 8'($urandom_range(255)), rand_word());
    endtask

    initial
    begin
        int sent;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty list, bad positions, head/middle/tail edits
        send_request(REQ_DUMP,    8'h00, rand_word());
        send_request(REQ_ERASE,   8'h00, rand_word());
        send_request(REQ_INSERT,  8'h01, rand_word());
        send_request(REQ_INSERT,  8'h80, rand_word());
        send_request(REQ_INSERT,  8'hFF, rand_word());
        send_request(REQ_INSERT,  8'h00, 32'h7FFF_FFFF);
        send_request(REQ_INSERT,  8'h01, 32'h8000_0000);
        send_request(REQ_INSERT,  8'h00, 32'hFFFF_FFFF);
        send_request(REQ_INSERT,  8'h02, 32'h0000_0000);
        send_request(REQ_DUMP,    8'h7F, rand_word());
        send_request(REQ_UNKNOWN, 8'h00, rand_word());
        send_request(REQ_ERASE,   8'h7F, rand_word());
        send_request(REQ_ERASE,   8'h04, rand_word());
        send_request(REQ_ERASE,   8'hFF, rand_word());
        send_request(REQ_ERASE,   8'h01, rand_word());
        send_request(REQ_ERASE,   8'h02, rand_word());
        send_request(REQ_ERASE,   8'h00, rand_word());
        send_request(REQ_DUMP,    8'h00, rand_word());
        directed_count = 18;
        wait_drained();

        // fill to capacity, then full and range cases on a full store
        sent = 0;
        while (list_len < LIST_CAPACITY)
        begin
            send_request(REQ_INSERT, 8'($urandom_range(0, list_len)), rand_word());
            sent++;
        end
        send_request(REQ_INSERT, 8'(LIST_CAPACITY), rand_word());
        send_request(REQ_INSERT, 8'($urandom_range(0, LIST_CAPACITY - 1)), rand_word());
        send_request(REQ_INSERT, 8'(LIST_CAPACITY + 1), rand_word());
        send_request(REQ_DUMP, 8'($urandom_range(255)), rand_word());
        sent += 4;

        while (sent < RANDOM_ITEMS)
        begin
            if (sent == 60)
                calm <= 1'b1;
            if (sent == 110)
                calm <= 1'b0;
            if (sent == 90)
                wait_drained();
            if (sent == 130)
            begin
                while (list_len > 0)
                begin
                    send_request(REQ_ERASE, 8'($urandom_range(0, list_len - 1)),
                                 rand_word());
                    sent++;
                end
                send_request(REQ_DUMP, 8'($urandom_range(255)), rand_word());
                sent++;
            end
            send_mixed();
            sent++;
        end

        wait_drained();
        repeat (20) @(negedge clk);
        $display("%0d requests (%0d directed) gave %0d results, %0d mismatches",
                 requests_seen, directed_count, results_seen, errors);
        $display("list filled to %0d of %0d entries, drained to empty, random stalls both sides",
                 peak_len, LIST_CAPACITY);
        if (errors == 0)
            $display("positional_list_engine regression: pass");
        else
            $display("positional_list_engine regression: fail");
        $finish;
    end

endmodule
